FILE: hdl/quad_x_motor_mixer_with_arming_top_assert.svh
// Assertion macros for the quad X motor mixer.
// Used by the top level; no other dependencies.
`ifndef QUAD_X_MOTOR_MIXER_WITH_ARMING_TOP_ASSERT_SVH
`define QUAD_X_MOTOR_MIXER_WITH_ARMING_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define QXMM_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("qxmm assertion failed");
`define QXMM_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("qxmm assertion failed");
`else
`define QXMM_ASSERT(lbl, clk, rst_n, prop)
`define QXMM_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

FILE: hdl/qxmm_pkg.sv
// Shared types and constants for the quad X motor mixer.
// No dependencies.
`default_nettype none

package qxmm_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_ARM_THRESHOLD    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF_THRESHOLD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THROTTLE_OFFSET  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_LIMIT       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_LIMIT     = 3'd4;

    localparam logic [15:0] RST_ARM_THRESHOLD    = 16'd1100;
    localparam logic [15:0] RST_CUTOFF_THRESHOLD = 16'd1050;
    localparam logic [15:0] RST_THROTTLE_OFFSET  = 16'd1000;
    localparam logic [9:0]  RST_BASE_LIMIT       = 10'd900;
    localparam logic [15:0] RST_OUTPUT_LIMIT     = 16'd1000;

    typedef struct packed {
        logic [15:0] arm_threshold;
        logic [15:0] cutoff_threshold;
        logic [15:0] throttle_offset;
        logic [9:0]  base_limit;
        logic [15:0] output_limit;
    } t_cfg;

    typedef struct packed {
        logic [15:0]        throttle;
        logic               disarm_request;
        logic signed [15:0] correction_x;
        logic signed [15:0] correction_y;
        logic signed [15:0] correction_z;
    } t_in_item;

    typedef struct packed {
        logic [15:0] drive_one;
        logic [15:0] drive_two;
        logic [15:0] drive_three;
        logic [15:0] drive_four;
        logic [1:0]  arm_state;
    } t_out_item;

endpackage

`default_nettype wire

FILE: hdl/qxmm_in_if.sv
// Input channel of the quad X motor mixer: control tick transaction.
// No dependencies.
`default_nettype none

interface qxmm_in_if;
    logic               valid;
    logic               ready;
    logic [15:0]        throttle;
    logic               disarm_request;
    logic signed [15:0] correction_x;
    logic signed [15:0] correction_y;
    logic signed [15:0] correction_z;

    modport source (
        output valid, throttle, disarm_request, correction_x, correction_y, correction_z,
        input  ready
    );
    modport sink (
        input  valid, throttle, disarm_request, correction_x, correction_y, correction_z,
        output ready
    );
endinterface

`default_nettype wire

FILE: hdl/qxmm_out_if.sv
// Output channel of the quad X motor mixer: motor drives and arm state.
// No dependencies.
`default_nettype none

interface qxmm_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] drive_one;
    logic [15:0] drive_two;
    logic [15:0] drive_three;
    logic [15:0] drive_four;
    logic [1:0]  arm_state;

    modport source (
        output valid, drive_one, drive_two, drive_three, drive_four, arm_state,
        input  ready
    );
    modport sink (
        input  valid, drive_one, drive_two, drive_three, drive_four, arm_state,
        output ready
    );
endinterface

`default_nettype wire

FILE: hdl/qxmm_cfg.sv
// Configuration register file of the quad X motor mixer.
// Depends on qxmm_pkg.
`default_nettype none

module qxmm_cfg
    import qxmm_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                       o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.arm_threshold    <= RST_ARM_THRESHOLD;
            r_cfg.cutoff_threshold <= RST_CUTOFF_THRESHOLD;
            r_cfg.throttle_offset  <= RST_THROTTLE_OFFSET;
            r_cfg.base_limit       <= RST_BASE_LIMIT;
            r_cfg.output_limit     <= RST_OUTPUT_LIMIT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ARM_THRESHOLD:    r_cfg.arm_threshold    <= i_cfg_data;
                CFG_CUTOFF_THRESHOLD: r_cfg.cutoff_threshold <= i_cfg_data;
                CFG_THROTTLE_OFFSET:  r_cfg.throttle_offset  <= i_cfg_data;
                CFG_BASE_LIMIT:       r_cfg.base_limit       <= i_cfg_data[9:0];
                CFG_OUTPUT_LIMIT:     r_cfg.output_limit     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

FILE: hdl/qxmm_mix.sv
// Base drive and X-frame mixing with clamps for the quad X motor mixer.
// Depends on qxmm_pkg.
`default_nettype none

module qxmm_mix
    import qxmm_pkg::*;
(
    input  wire t_cfg     i_cfg,
    input  wire t_in_item i_item,
    output t_out_item     o_drive
);

    function automatic logic [15:0] clamp_out(input logic signed [18:0] v,
                                              input logic [15:0] hi);
        logic signed [18:0] hi_s;
        hi_s = $signed({3'b000, hi});
        if (v < 0) begin
            return 16'd0;
        end else if (v > hi_s) begin
            return hi;
        end else begin
            return v[15:0];
        end
    endfunction

    logic signed [16:0] base_raw;
    logic [9:0]         base;
    logic signed [18:0] base_s;
    logic signed [18:0] cx;
    logic signed [18:0] cy;
    logic signed [18:0] cz;

    assign base_raw = $signed({1'b0, i_item.throttle}) - $signed({1'b0, i_cfg.throttle_offset});

    always_comb begin
        priority if (i_item.throttle < i_cfg.cutoff_threshold) begin
            base = '0;
        end else if (base_raw < 0) begin
            base = '0;
        end else if (base_raw > $signed({7'd0, i_cfg.base_limit})) begin
            base = i_cfg.base_limit;
        end else begin
            base = base_raw[9:0];
        end
    end

    assign base_s = $signed({9'd0, base});
    assign cx     = $signed({{3{i_item.correction_x[15]}}, i_item.correction_x});
    assign cy     = $signed({{3{i_item.correction_y[15]}}, i_item.correction_y});
    assign cz     = $signed({{3{i_item.correction_z[15]}}, i_item.correction_z});

    always_comb begin
        o_drive.drive_one   = clamp_out(base_s - cx - cy - cz, i_cfg.output_limit);
        o_drive.drive_two   = clamp_out(base_s + cx - cy + cz, i_cfg.output_limit);
        o_drive.drive_three = clamp_out(base_s - cx + cy + cz, i_cfg.output_limit);
        o_drive.drive_four  = clamp_out(base_s + cx + cy - cz, i_cfg.output_limit);
        o_drive.arm_state   = '0;
    end

endmodule

`default_nettype wire

FILE: hdl/quad_x_motor_mixer_with_arming_top.sv
// Quad X motor mixer with arming state machine.
//
// Usage:
// - i_in carries one control tick per transaction: throttle, disarm request and
//   the roll, pitch and yaw corrections. o_out returns one transaction per tick:
//   the four motor drives and the arm state after that tick.
// - Configuration is written through i_cfg_we / i_cfg_index / i_cfg_data, one
//   register per cycle, while no transaction is in flight.
// - Throughput: one transaction per cycle while o_out is not stalled. A tick
//   passes the input register, then mix and clamp into the output register,
//   which drives o_out.valid.
// - The arm state advances when a tick leaves the input register, so each tick
//   sees the state left by the one before it.
// - Reset clears both valid flags, sets the state to disarmed and loads the
//   default thresholds and limits.
// - While o_out is stalled the output register holds; the input register still
//   takes one more transaction, and i_in.ready drops once both are full.
// Depends on qxmm_pkg, qxmm_in_if, qxmm_out_if, qxmm_cfg, qxmm_mix and the
// assertion macro header.
`default_nettype none
`include "quad_x_motor_mixer_with_arming_top_assert.svh"

module quad_x_motor_mixer_with_arming_top
    import qxmm_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    qxmm_in_if.sink                    i_in,
    qxmm_out_if.source                 o_out,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    typedef enum logic [1:0] {
        PH_DISARMED = 2'd0,
        PH_WAITING  = 2'd1,
        PH_RUNNING  = 2'd2
    } t_phase;

    t_cfg      w_cfg;
    t_in_item  r_s1;
    logic      r_s1_valid;
    t_out_item r_out;
    t_out_item n_out;
    logic      r_out_valid;
    t_out_item w_mix;
    t_phase    r_phase;
    t_phase    n_phase;
    t_phase    w_phase_in;
    logic      w_run;
    logic      w_s2_ready;
    logic      w_s1_adv;
    logic      w_in_fire;
    logic      w_out_idle_ok;
    logic      w_out_in_lim;
    logic      w_running;
    logic      w_disarm_adv;

    qxmm_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    qxmm_mix u_mix (
        .i_cfg   (w_cfg),
        .i_item  (r_s1),
        .o_drive (w_mix)
    );

    assign w_s2_ready = !r_out_valid || o_out.ready;
    assign w_s1_adv   = r_s1_valid && w_s2_ready;
    assign i_in.ready = !r_s1_valid || w_s2_ready;
    assign w_in_fire  = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_s1.throttle       <= i_in.throttle;
            r_s1.disarm_request <= i_in.disarm_request;
            r_s1.correction_x   <= i_in.correction_x;
            r_s1.correction_y   <= i_in.correction_y;
            r_s1.correction_z   <= i_in.correction_z;
        end
    end

    always_comb begin
        w_phase_in = r_s1.disarm_request ? PH_DISARMED : r_phase;
        w_run      = 1'b0;
        unique case (w_phase_in)
            PH_WAITING: begin
                n_phase = (r_s1.throttle > w_cfg.arm_threshold) ? PH_RUNNING : PH_WAITING;
            end
            PH_RUNNING: begin
                n_phase = PH_RUNNING;
                w_run   = 1'b1;
            end
            default: begin
                n_phase = PH_WAITING;
            end
        endcase
        n_out.drive_one   = w_run ? w_mix.drive_one   : 16'd0;
        n_out.drive_two   = w_run ? w_mix.drive_two   : 16'd0;
        n_out.drive_three = w_run ? w_mix.drive_three : 16'd0;
        n_out.drive_four  = w_run ? w_mix.drive_four  : 16'd0;
        n_out.arm_state   = n_phase;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_DISARMED;
            r_out_valid <= 1'b0;
        end else begin
            if (w_s1_adv) begin
                r_phase <= n_phase;
                r_out   <= n_out;
            end
            if (w_s2_ready) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.drive_one   = r_out.drive_one;
    assign o_out.drive_two   = r_out.drive_two;
    assign o_out.drive_three = r_out.drive_three;
    assign o_out.drive_four  = r_out.drive_four;
    assign o_out.arm_state   = r_out.arm_state;

    assign w_out_idle_ok = (r_out.arm_state == PH_RUNNING) ||
                           (r_out.drive_one == 16'd0 && r_out.drive_two == 16'd0 &&
                            r_out.drive_three == 16'd0 && r_out.drive_four == 16'd0);
    assign w_out_in_lim  = r_out.drive_one <= w_cfg.output_limit &&
                           r_out.drive_two <= w_cfg.output_limit &&
                           r_out.drive_three <= w_cfg.output_limit &&
                           r_out.drive_four <= w_cfg.output_limit;
    assign w_running     = (r_phase == PH_RUNNING);
    assign w_disarm_adv  = w_s1_adv && r_s1.disarm_request;

    `QXMM_ASSERT(a_idle_zero, i_clk, i_rst_n, r_out_valid |-> w_out_idle_ok)
    `QXMM_ASSERT(a_drive_limit, i_clk, i_rst_n, r_out_valid |-> w_out_in_lim)
    `QXMM_ASSERT(a_run_from_wait, i_clk, i_rst_n, $rose(w_running) |-> $past(r_phase) == PH_WAITING)
    `QXMM_ASSERT(a_disarm_wait, i_clk, i_rst_n, w_disarm_adv |=> r_phase == PH_WAITING)

endmodule

`default_nettype wire

FILE: tb/sv/quad_x_motor_mixer_with_arming_top_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the quad X motor mixer with arming.
// Random and directed control ticks with random stalls, checked against an in-bench model.
// Depends on qxmm_pkg, qxmm_in_if, qxmm_out_if and quad_x_motor_mixer_with_arming_top.

module quad_x_motor_mixer_with_arming_top_test
    import qxmm_pkg::*;
;
    localparam int STALL_LIMIT = 2000;
    localparam int LONG_HOLD   = 200;

    typedef enum logic [1:0] {
        PH_DISARMED = 2'd0,
        PH_WAITING  = 2'd1,
        PH_RUNNING  = 2'd2
    } t_arm_phase;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    qxmm_in_if  in_if ();
    qxmm_out_if out_if ();

    quad_x_motor_mixer_with_arming_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in        (in_if),
        .o_out       (out_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    t_cfg        mix_cfg;
    t_arm_phase  arm_phase;
    t_in_item    tick_q[$];
    t_out_item   drive_expect_q[$];
    t_in_item    cur_tick;
    int unsigned idle_pct;
    int          src_wait;
    int          sink_wait;
    int          quiet_cycles;
    int          error_count;
    bit          long_hold_req;
    bit          long_hold_done;

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic int clamp_to(int v, int hi);
        if (v < 0) return 0;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic t_out_item mix_tick(t_in_item t);
        t_out_item r;
        int        base;
        int        lim;
        int        cx;
        int        cy;
        int        cz;
        r  = '0;
        cx = $signed(t.correction_x);
        cy = $signed(t.correction_y);
        cz = $signed(t.correction_z);
        if (t.disarm_request) arm_phase = PH_DISARMED;
        case (arm_phase)
            PH_WAITING: begin
                if (t.throttle > mix_cfg.arm_threshold) arm_phase = PH_RUNNING;
            end
            PH_RUNNING: begin
                base = int'({16'd0, t.throttle}) - int'({16'd0, mix_cfg.throttle_offset});
                lim  = int'({16'd0, mix_cfg.output_limit});
                if (t.throttle < mix_cfg.cutoff_threshold) base = 0;
                base = clamp_to(base, int'({22'd0, mix_cfg.base_limit}));
                r.drive_one   = 16'(clamp_to(base - cx - cy - cz, lim));
                r.drive_two   = 16'(clamp_to(base + cx - cy + cz, lim));
                r.drive_three = 16'(clamp_to(base - cx + cy + cz, lim));
                r.drive_four  = 16'(clamp_to(base + cx + cy - cz, lim));
            end
            default: begin
                arm_phase = PH_WAITING;
            end
        endcase
        r.arm_state = arm_phase;
        return r;
    endfunction

    function automatic logic signed [15:0] random_correction();
        int unsigned sel;
        int          v;
        sel = $urandom_range(99);
        if (sel < 60) v = int'($urandom_range(800)) - 400;
        else if (sel < 80) v = int'($urandom_range(6000)) - 3000;
        else if (sel < 90) v = ($urandom_range(1) != 0) ? 32767 : -32768;
        else v = int'($urandom);
        return 16'(v);
    endfunction

    function automatic t_in_item random_tick();
        t_in_item    t;
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 55) t.throttle = 16'($urandom_range(2300, 900));
        else if (sel < 67) t.throttle = mix_cfg.arm_threshold + 16'($urandom_range(2)) - 16'd1;
        else if (sel < 77) t.throttle = mix_cfg.cutoff_threshold + 16'($urandom_range(2)) - 16'd1;
        else t.throttle = 16'($urandom);
        t.disarm_request = ($urandom_range(99) < 4);
        t.correction_x   = random_correction();
        t.correction_y   = random_correction();
        t.correction_z   = random_correction();
        return t;
    endfunction

    task automatic push_tick(input logic [15:0] thr, input logic dis,
                             input int x, input int y, input int z);
        t_in_item t;
        t.throttle       = thr;
        t.disarm_request = dis;
        t.correction_x   = 16'(x);
        t.correction_y   = 16'(y);
        t.correction_z   = 16'(z);
        tick_q.push_back(t);
    endtask

    task automatic drain();
        @(negedge clk);
        while (tick_q.size() != 0 || in_if.valid || drive_expect_q.size() != 0) @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic run_random(input int n);
        repeat (n) tick_q.push_back(random_tick());
        drain();
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_ARM_THRESHOLD:    mix_cfg.arm_threshold    = val;
            CFG_CUTOFF_THRESHOLD: mix_cfg.cutoff_threshold = val;
            CFG_THROTTLE_OFFSET:  mix_cfg.throttle_offset  = val;
            CFG_BASE_LIMIT:       mix_cfg.base_limit       = val[9:0];
            CFG_OUTPUT_LIMIT:     mix_cfg.output_limit     = val;
            default: ;
        endcase
    endtask

    task automatic load_config(input logic [15:0] arm, input logic [15:0] cut,
                               input logic [15:0] off, input logic [15:0] blim,
                               input logic [15:0] olim);
        write_reg(CFG_ARM_THRESHOLD, arm);
        write_reg(CFG_CUTOFF_THRESHOLD, cut);
        write_reg(CFG_THROTTLE_OFFSET, off);
        write_reg(CFG_BASE_LIMIT, blim);
        write_reg(CFG_OUTPUT_LIMIT, olim);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
            error_count++;
        end
    endtask

    // driver: hold the current transaction until accepted, then advance
    always @(posedge clk) begin
        if (!rst_n) begin
            in_if.valid <= 1'b0;
            src_wait = 0;
        end else begin
            if (in_if.valid && in_if.ready) drive_expect_q.push_back(mix_tick(cur_tick));
            if (!in_if.valid || in_if.ready) begin
                if (src_wait > 0) begin
                    src_wait--;
                    in_if.valid <= 1'b0;
                end else if (tick_q.size() == 0) begin
                    in_if.valid <= 1'b0;
                end else if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
                    src_wait = $urandom_range(7);
                    in_if.valid <= 1'b0;
                end else begin
                    cur_tick = tick_q.pop_front();
                    in_if.valid          <= 1'b1;
                    in_if.throttle       <= cur_tick.throttle;
                    in_if.disarm_request <= cur_tick.disarm_request;
                    in_if.correction_x   <= cur_tick.correction_x;
                    in_if.correction_y   <= cur_tick.correction_y;
                    in_if.correction_z   <= cur_tick.correction_z;
                end
            end
        end
    end

    // monitor: compare each drive transaction with the oldest expectation
    always @(posedge clk) begin
        t_out_item exp_r;
        if (!rst_n) begin
            out_if.ready <= 1'b0;
            sink_wait = 0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (drive_expect_q.size() == 0) begin
                    $display("%0t: drive transaction with nothing expected", $time);
                    error_count++;
                end else begin
                    exp_r = drive_expect_q.pop_front();
                    check_field("drive_one", exp_r.drive_one, out_if.drive_one);
                    check_field("drive_two", exp_r.drive_two, out_if.drive_two);
                    check_field("drive_three", exp_r.drive_three, out_if.drive_three);
                    check_field("drive_four", exp_r.drive_four, out_if.drive_four);
                    check_field("arm_state", exp_r.arm_state, out_if.arm_state);
                end
            end
            if (long_hold_req && !long_hold_done) begin
                long_hold_done = 1'b1;
                sink_wait = LONG_HOLD;
            end
            if (sink_wait > 0) begin
                sink_wait--;
                out_if.ready <= 1'b0;
            end else if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
                sink_wait = $urandom_range(7);
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("quad_x_motor_mixer_with_arming_top_test NOT OK");
                $finish;
            end
        end
    end

    initial begin
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_index            = '0;
        cfg_data             = '0;
        in_if.valid          = 1'b0;
        in_if.throttle       = '0;
        in_if.disarm_request = 1'b0;
        in_if.correction_x   = '0;
        in_if.correction_y   = '0;
        in_if.correction_z   = '0;
        out_if.ready         = 1'b0;
        error_count          = 0;
        quiet_cycles         = 0;
        long_hold_req        = 1'b0;
        long_hold_done       = 1'b0;
        idle_pct             = 25;
        arm_phase            = PH_DISARMED;
        mix_cfg.arm_threshold    = RST_ARM_THRESHOLD;
        mix_cfg.cutoff_threshold = RST_CUTOFF_THRESHOLD;
        mix_cfg.throttle_offset  = RST_THROTTLE_OFFSET;
        mix_cfg.base_limit       = RST_BASE_LIMIT;
        mix_cfg.output_limit     = RST_OUTPUT_LIMIT;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // arming sequence, cutoff and clamp edges with the reset settings
        push_tick(16'd0, 1'b0, 0, 0, 0);
        push_tick(16'd1100, 1'b0, 0, 0, 0);
        push_tick(16'd1101, 1'b0, 100, 100, 100);
        push_tick(16'd1049, 1'b0, 0, 0, 0);
        push_tick(16'd1049, 1'b0, -5, -5, -5);
        push_tick(16'd1050, 1'b0, 0, 0, 0);
        push_tick(16'd1900, 1'b0, 0, 0, 0);
        push_tick(16'd65535, 1'b0, 0, 0, 0);
        push_tick(16'd1500, 1'b0, 100, -50, 25);
        push_tick(16'd1500, 1'b0, 32767, -32768, 0);
        push_tick(16'd65535, 1'b0, -32768, -32768, -32768);
        push_tick(16'd1500, 1'b0, 32767, 32767, 32767);
        push_tick(16'd2000, 1'b1, 50, 50, 50);
        push_tick(16'd1100, 1'b0, 0, 0, 0);
        push_tick(16'd65535, 1'b0, -1, -1, -1);
        push_tick(16'd1200, 1'b0, -300, 200, -100);
        push_tick(16'd1400, 1'b1, 0, 0, 0);
        push_tick(16'd0, 1'b0, 0, 0, 0);
        push_tick(16'd1101, 1'b0, 0, 0, 0);
        drain();

        // offset above throttle, widest base and output limits
        load_config(RST_ARM_THRESHOLD, 16'd0, 16'd2000, 16'hFFFF, 16'hFFFF);
        push_tick(16'd1500, 1'b0, 0, 0, 0);
        push_tick(16'd1500, 1'b0, 10, 20, 30);
        push_tick(16'd65535, 1'b0, 0, 0, 0);
        push_tick(16'd65535, 1'b0, -32768, -32768, -32768);
        push_tick(16'd65535, 1'b0, 32767, -32768, 32767);
        drain();

        load_config(RST_ARM_THRESHOLD, RST_CUTOFF_THRESHOLD, RST_THROTTLE_OFFSET,
                    16'(RST_BASE_LIMIT), RST_OUTPUT_LIMIT);
        long_hold_req = 1'b1;
        run_random(150);

        load_config(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        run_random(40);
        load_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_random(40);

        for (int k = 0; k < 4; k++) begin
            idle_pct = (k == 1) ? 0 : 25;
            if (k == 3) begin
                load_config(16'($urandom), 16'($urandom), 16'($urandom),
                            16'($urandom), 16'($urandom));
            end else begin
                load_config(16'($urandom_range(3000)), 16'($urandom_range(2500)),
                            16'($urandom_range(2500)), 16'($urandom_range(1023)),
                            16'($urandom_range(1500)));
            end
            run_random(50);
        end

        load_config(RST_ARM_THRESHOLD, RST_CUTOFF_THRESHOLD, RST_THROTTLE_OFFSET,
                    16'(RST_BASE_LIMIT), RST_OUTPUT_LIMIT);
        idle_pct = 0;
        run_random(60);
        repeat (8) @(posedge clk);

        if (error_count == 0 && drive_expect_q.size() == 0) begin
            $display("quad_x_motor_mixer_with_arming_top_test OK");
        end else begin
            $display("quad_x_motor_mixer_with_arming_top_test NOT OK");
        end
        $finish;
    end

endmodule
